// ----- hw/rtl/ccmc_pkg.sv -----
// Shared types and constants for the column color match centroid block.
package ccmc_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int FRAC_BITS = 4;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 11;
    localparam int MEAN_W  = 14;
    localparam int TOL_W   = 10;
    localparam int HGT_W   = 11;
    localparam int DIV_W   = SUM_W + FRAC_BITS;   // dividend width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int PIPE_D  = 4;                   // skid queue depth (front -> back)
    localparam int PIPE_AW = 2;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_RED   = 3'd0,
        CFG_REF_GREEN = 3'd1,
        CFG_REF_BLUE  = 3'd2,
        CFG_TOLERANCE = 3'd3,
        CFG_ROWS      = 3'd4
    } t_cfg_idx;

    // Classified pixel handed from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             match;
        logic             first;  // row 0: restart column
        logic             last;   // closing row
    } t_pix_cls;

    // Quotient work item inside the divider pipeline.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        logic [CNT_W-1:0] den;
    } t_div_stage;

endpackage

// ----- hw/rtl/ccmc_if.sv -----
// Valid/ready stream interfaces for pixels, results and configuration writes.
interface ccmc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [ccmc_pkg::ROW_W-1:0] pixel_row;
    logic [ccmc_pkg::COL_W-1:0] pixel_col;
    modport source (output valid, red, green, blue, pixel_row, pixel_col, input ready);
    modport sink   (input valid, red, green, blue, pixel_row, pixel_col, output ready);
endinterface

interface ccmc_res_if;
    logic valid;
    logic ready;
    logic [ccmc_pkg::COL_W-1:0]  peak_col;
    logic [ccmc_pkg::MEAN_W-1:0] peak_row_fixed;
    modport source (output valid, peak_col, peak_row_fixed, input ready);
    modport sink   (input valid, peak_col, peak_row_fixed, output ready);
endinterface

interface ccmc_cfg_if;
    logic valid;
    logic ready;
    logic [ccmc_pkg::CFG_IDX_W-1:0] index;
    logic [ccmc_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ccmc_front.sv -----
// Front end: holds configuration, classifies pixels, pushes them into a short queue.
module ccmc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ccmc_pix_if.sink            pix,
    ccmc_cfg_if.sink            cfg,
    input  logic                i_pop,
    output logic                o_q_valid,
    output ccmc_pkg::t_pix_cls  o_q_data
);
    logic [7:0] r_ref_red, r_ref_green, r_ref_blue;
    logic [ccmc_pkg::TOL_W-1:0] r_tol;
    logic [ccmc_pkg::HGT_W-1:0] r_rows;

    ccmc_pkg::t_pix_cls r_q [ccmc_pkg::PIPE_D];
    logic [ccmc_pkg::PIPE_AW-1:0] r_wp, r_rp;
    logic [ccmc_pkg::PIPE_AW:0]   r_cnt;

    logic [8:0]  d_r, d_g, d_b;
    logic [9:0]  color_dist;
    logic [ccmc_pkg::HGT_W-1:0] last_row;
    ccmc_pkg::t_pix_cls cls;
    logic push, pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_red   <= 8'd255;
            r_ref_green <= 8'd0;
            r_ref_blue  <= 8'd0;
            r_tol       <= ccmc_pkg::TOL_W'(100);
            r_rows      <= ccmc_pkg::HGT_W'(480);
        end else if (cfg.valid) begin
            unique case (ccmc_pkg::t_cfg_idx'(cfg.index))
                ccmc_pkg::CFG_REF_RED:   r_ref_red   <= cfg.data[7:0];
                ccmc_pkg::CFG_REF_GREEN: r_ref_green <= cfg.data[7:0];
                ccmc_pkg::CFG_REF_BLUE:  r_ref_blue  <= cfg.data[7:0];
                ccmc_pkg::CFG_TOLERANCE: r_tol       <= cfg.data[ccmc_pkg::TOL_W-1:0];
                ccmc_pkg::CFG_ROWS:      r_rows      <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        d_r  = (pix.red   > r_ref_red)   ? 9'(pix.red - r_ref_red)     : 9'(r_ref_red - pix.red);
        d_g  = (pix.green > r_ref_green) ? 9'(pix.green - r_ref_green) : 9'(r_ref_green - pix.green);
        d_b  = (pix.blue  > r_ref_blue)  ? 9'(pix.blue - r_ref_blue)   : 9'(r_ref_blue - pix.blue);
        color_dist = 10'(d_r) + 10'(d_g) + 10'(d_b);
        last_row  = r_rows - ccmc_pkg::HGT_W'(1);
        cls.col   = pix.pixel_col;
        cls.row   = pix.pixel_row;
        cls.match = color_dist < r_tol;
        cls.first = pix.pixel_row == '0;
        cls.last  = (r_rows != '0) && (ccmc_pkg::HGT_W'(pix.pixel_row) == last_row);
    end

    assign pix.ready = r_cnt != ccmc_pkg::PIPE_D[ccmc_pkg::PIPE_AW:0];
    assign push      = pix.valid && pix.ready;
    assign o_q_valid = r_cnt != '0;
    assign o_q_data  = r_q[r_rp];
    assign pop       = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (ccmc_pkg::PIPE_AW+1)'(push) - (ccmc_pkg::PIPE_AW+1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/ccmc_accum.sv -----
// Back end accumulator: per-column row sum and match count in a memory.
module ccmc_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  ccmc_pkg::t_pix_cls        i_q_data,
    output logic                      o_pop,
    input  logic                      i_div_ready,
    output logic                      o_div_valid,
    output logic [ccmc_pkg::COL_W-1:0] o_div_col,
    output logic [ccmc_pkg::SUM_W-1:0] o_div_sum,
    output logic [ccmc_pkg::CNT_W-1:0] o_div_cnt
);
    logic [ccmc_pkg::SUM_W+ccmc_pkg::CNT_W-1:0] r_mem [ccmc_pkg::MAX_COLS];

    // Stage 1: registered read of the memory.
    logic               r_s1_v;
    ccmc_pkg::t_pix_cls r_s1;
    logic [ccmc_pkg::SUM_W+ccmc_pkg::CNT_W-1:0] r_rd;
    // Stage 2: writeback; forward to a following pixel of the same column.
    logic               r_s2_v;
    logic [ccmc_pkg::COL_W-1:0] r_s2_col;
    logic [ccmc_pkg::SUM_W-1:0] r_s2_sum;
    logic [ccmc_pkg::CNT_W-1:0] r_s2_cnt;

    logic [ccmc_pkg::SUM_W-1:0] old_sum, n_sum;
    logic [ccmc_pkg::CNT_W-1:0] old_cnt, n_cnt;
    logic [ccmc_pkg::SUM_W:0]   add;
    logic stall, emit;

    assign emit  = r_s1_v && r_s1.last && (n_cnt != '0);
    assign stall = emit && !i_div_ready;
    assign o_pop = i_q_valid && !stall;

    always_comb begin
        if (r_s2_v && r_s2_col == r_s1.col) begin
            old_sum = r_s2_sum;
            old_cnt = r_s2_cnt;
        end else begin
            old_sum = r_rd[ccmc_pkg::SUM_W+ccmc_pkg::CNT_W-1:ccmc_pkg::CNT_W];
            old_cnt = r_rd[ccmc_pkg::CNT_W-1:0];
        end
        if (r_s1.first) begin
            old_sum = '0;
            old_cnt = '0;
        end
        add   = (ccmc_pkg::SUM_W+1)'(old_sum) + (ccmc_pkg::SUM_W+1)'(r_s1.row);
        n_sum = old_sum;
        n_cnt = old_cnt;
        if (r_s1.match) begin
            n_sum = add[ccmc_pkg::SUM_W] ? ccmc_pkg::SUM_MAX : add[ccmc_pkg::SUM_W-1:0];
            n_cnt = (old_cnt == ccmc_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;
        end
    end

    assign o_div_valid = emit;
    assign o_div_col   = r_s1.col;
    assign o_div_sum   = n_sum;
    assign o_div_cnt   = n_cnt;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rd <= r_mem[i_q_data.col];
        if (r_s1_v && !stall) r_mem[r_s1.col] <= {n_sum, n_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1     <= i_q_data;
            r_s2_col <= r_s1.col;
            r_s2_sum <= n_sum;
            r_s2_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (!stall) begin
            r_s1_v <= o_pop;
            r_s2_v <= r_s1_v;
        end
    end
endmodule

// ----- hw/rtl/ccmc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, saturating mean.
module ccmc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ccmc_pkg::COL_W-1:0] i_col,
    input  logic [ccmc_pkg::SUM_W-1:0] i_sum,
    input  logic [ccmc_pkg::CNT_W-1:0] i_cnt,
    ccmc_res_if.source                 res
);
    localparam int N = ccmc_pkg::DIV_W;

    ccmc_pkg::t_div_stage r_st [N];
    logic [N-1:0] r_v;
    logic adv;
    ccmc_pkg::t_div_stage st_in [N];
    ccmc_pkg::t_div_stage st_out [N];
    logic [N-1:0] q_full;

    // Whole pipeline advances together; an empty output slot lets it move.
    assign adv     = !r_v[N-1] || res.ready;
    assign o_ready = adv;

    always_comb begin
        st_in[0].col = i_col;
        st_in[0].rem = '0;
        st_in[0].quo = {i_sum, {ccmc_pkg::FRAC_BITS{1'b0}}};
        st_in[0].den = i_cnt;
        for (int k = 1; k < N; k++) st_in[k] = r_st[k-1];
        for (int k = 0; k < N; k++) begin
            logic [N:0] trial;
            trial = {st_in[k].rem, st_in[k].quo[N-1]} - (N+1)'(st_in[k].den);
            st_out[k].col = st_in[k].col;
            st_out[k].den = st_in[k].den;
            if (!trial[N]) begin
                st_out[k].rem = trial[N-1:0];
                st_out[k].quo = {st_in[k].quo[N-2:0], 1'b1};
            end else begin
                st_out[k].rem = {st_in[k].rem[N-2:0], st_in[k].quo[N-1]};
                st_out[k].quo = {st_in[k].quo[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) for (int k = 0; k < N; k++) r_st[k] <= st_out[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[N-2:0], i_valid};
    end

    assign q_full = r_st[N-1].quo;
    assign res.valid = r_v[N-1];
    assign res.peak_col = r_st[N-1].col;
    assign res.peak_row_fixed = (q_full[N-1:ccmc_pkg::MEAN_W] != '0) ? ccmc_pkg::MEAN_MAX
                                                                    : q_full[ccmc_pkg::MEAN_W-1:0];
endmodule

// ----- hw/rtl/column_color_match_centroid_top.sv -----
// Top level of the column color match centroid laser-line detector.
// Takes one pixel transfer per clock in raster order. The front classifies
// each pixel (color distance below tolerance, row 0, closing row) and keeps
// the configuration; a four-entry queue decouples it from the back, which
// accumulates per column in a 1024-entry memory with a registered read and
// a write forward, then divides on the closing row through a 23-stage
// pipelined divider (one quotient bit a stage). Sustained rate is one pixel
// per clock while results are taken; a pixel passes the queue, the
// accumulator's registered read and the divider before its result shows.
// Output stalls freeze the divider, the accumulator holds at the next
// closing pixel with matches, the queue fills, then input ready drops.
// Configuration writes are always taken; write only while idle.
module column_color_match_centroid_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccmc_pix_if.sink   pix,
    ccmc_cfg_if.sink   cfg,
    ccmc_res_if.source res
);
    logic               q_valid, pop;
    ccmc_pkg::t_pix_cls q_data;
    logic               div_valid, div_ready;
    logic [ccmc_pkg::COL_W-1:0] div_col;
    logic [ccmc_pkg::SUM_W-1:0] div_sum;
    logic [ccmc_pkg::CNT_W-1:0] div_cnt;

    // Classify and queue.
    ccmc_front u_front (
        .i_clk, .i_rst_n, .pix, .cfg,
        .i_pop(pop), .o_q_valid(q_valid), .o_q_data(q_data)
    );

    // Accumulate per column, emit closing columns with matches.
    ccmc_accum u_accum (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_data(q_data), .o_pop(pop),
        .i_div_ready(div_ready), .o_div_valid(div_valid),
        .o_div_col(div_col), .o_div_sum(div_sum), .o_div_cnt(div_cnt)
    );

    // Mean = (sum << FRAC_BITS) / count, saturated.
    ccmc_div u_div (
        .i_clk, .i_rst_n,
        .i_valid(div_valid), .o_ready(div_ready),
        .i_col(div_col), .i_sum(div_sum), .i_cnt(div_cnt), .res
    );
endmodule

// ----- hw/rtl/ccmc_checker.sv -----
// Port-level checker for the column color match centroid top level.
module ccmc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic pix_ready,
    input logic res_valid,
    input logic res_ready,
    input logic [ccmc_pkg::COL_W-1:0]  res_col,
    input logic [ccmc_pkg::MEAN_W-1:0] res_mean,
    input logic cfg_ready
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_col) && $stable(res_mean))
        else $error("result changed while stalled");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) cfg_ready)
        else $error("config port not ready");
    a_no_res_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !res_valid)
        else $error("result right after reset");
    a_in_ready_rst: assert property (@(posedge i_clk) !i_rst_n |=> pix_ready)
        else $error("input not ready after reset");
endmodule

bind column_color_match_centroid_top ccmc_checker u_ccmc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .pix_ready(pix.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .res_col(res.peak_col), .res_mean(res.peak_row_fixed),
    .cfg_ready(cfg.ready)
);
